FILE: rtl/core/josephus_permutation_generator_defines.svh
// Assertion helpers used by the checker file of this block.
`ifndef JOSEPHUS_PERMUTATION_GENERATOR_DEFINES_SVH
`define JOSEPHUS_PERMUTATION_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define JPG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("josephus checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is held.
`define JPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("josephus checker: next-cycle property failed");

`endif

FILE: rtl/core/jpg_pkg.sv
`default_nettype none

package jpg_pkg;

    // Width of the register and result fields.
    localparam int FIELD_W = 13;

    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Default ring size.
    localparam int DEF_RING_DEPTH = 4096;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PEOPLE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT   = 1'd1;

    typedef logic [FIELD_W-1:0] t_field;

endpackage

`default_nettype wire

FILE: rtl/core/jpg_ring_mem.sv
`default_nettype none

// Simple dual-port ring memory: one write port, one registered read port.
module jpg_ring_mem #(
    parameter int DEPTH = jpg_pkg::DEF_RING_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [AW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [AW-1:0] o_rd_data
);

    logic [AW-1:0] r_mem [0:DEPTH-1];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/jpg_mod.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module jpg_mod #(
    parameter int CW = 13
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [jpg_pkg::FIELD_W-1:0] i_dividend,
    input  wire logic [CW-1:0]             i_divisor,
    output logic                           o_done,
    output logic      [CW-1:0]             o_rem
);

    localparam int KW  = jpg_pkg::FIELD_W;
    localparam int NW  = $clog2(KW + 1);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [KW-1:0] r_a;
    logic [CW-1:0] r_rem;
    logic [CW+1:0] n_shift;
    logic [CW+1:0] n_diff;

    // Bring in the next dividend bit and try the subtraction.
    assign n_shift = {1'b0, r_rem, r_a[KW-1]};
    assign n_diff  = n_shift - {2'b00, i_divisor};

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == NW'(KW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(KW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Partial remainder and dividend shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_a <= {r_a[KW-2:0], 1'b0};
            if (!n_diff[CW+1]) begin
                r_rem <= n_diff[CW-1:0];
            end else begin
                r_rem <= n_shift[CW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: rtl/core/josephus_permutation_generator.sv
// Restart and empty-ring requests: result valid in the cycle after the request is taken.
// Removal: t = (k-1) mod count front-to-back moves, one per cycle through the ring
// memory, after a pass through the remainder unit when k-1 >= count.
// One request is in work at a time; the next is taken once the result slot is free.
// Synchronous active-low reset empties the ring, sets n = k = 1; no clearing pass.
`default_nettype none

module josephus_permutation_generator #(
    parameter int RING_DEPTH = jpg_pkg::DEF_RING_DEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write channel.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [jpg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [jpg_pkg::FIELD_W-1:0]         i_cfg_data,
    // Request stream.
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [jpg_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // [0] restart
    // Result stream.
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    output logic      [jpg_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,  // [12:0] removed_member
    output logic                                     o_m_axis_tlast,  // last_removed
    output logic                                     o_m_axis_tuser   // [0] empty_error
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam int EW = AW + 2;
    localparam int FW = jpg_pkg::FIELD_W;
    localparam int XW = (CW > FW) ? CW : FW;
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_ROT  = 2'd2;
    localparam logic [1:0] ST_TAKE = 2'd3;

    logic [1:0]            r_state;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_nload;
    logic [CW-1:0]         r_wcnt;
    logic [CW-1:0]         r_left;
    logic                  r_wp_valid;
    logic [AW-1:0]         r_wp_addr;
    logic                  r_rd_orig;
    logic [AW-1:0]         r_rd_pos;
    jpg_pkg::t_field       r_people;
    jpg_pkg::t_field       r_step;
    logic                  r_out_valid;
    jpg_pkg::t_field       r_out_member;
    logic                  r_out_last;
    logic                  r_out_err;

    logic                  s_accept;
    logic                  out_free;
    logic                  out_load;
    logic                  rd_en;
    logic [AW-1:0]         rd_data;
    logic [AW-1:0]         rd_value;
    logic [AW:0]           member_w;
    jpg_pkg::t_field       n_km1;
    logic                  n_km1_lt;
    logic [CW-1:0]         n_sat;
    logic [AW-1:0]         n_head_inc;
    logic [CW-1:0]         n_tail_sum;
    logic [AW-1:0]         n_tail;
    logic                  n_orig;
    logic                  mod_start;
    logic                  mod_done;
    logic [CW-1:0]         mod_rem;

    // Configuration is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_people <= jpg_pkg::t_field'(1);
            r_step   <= jpg_pkg::t_field'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jpg_pkg::REG_PEOPLE_COUNT: r_people <= i_cfg_data;
                jpg_pkg::REG_STEP_COUNT:   r_step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request decode helpers.
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // A new result enters the result register this cycle.
    assign out_load = (s_accept && (i_s_axis_tdata[0] || (r_count == '0))) ||
                      ((r_state == ST_TAKE) && out_free);

    assign n_km1    = (r_step == '0) ? '0 : r_step - 1'b1;
    assign n_km1_lt = XW'(n_km1) < XW'(r_count);
    assign n_sat    = (XW'(r_people) > XW'(DEPTH_C)) ? DEPTH_C : CW'(r_people);

    // Ring index arithmetic, wrapping at the ring depth.
    assign n_head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign n_tail_sum = {1'b0, r_head} + r_count;
    assign n_tail     = (n_tail_sum >= DEPTH_C) ? AW'(n_tail_sum - DEPTH_C)
                                                : AW'(n_tail_sum);

    // An entry still holds its restart value if it lies below the loaded count and
    // the tail writes since restart, which run upward from that count, missed it.
    assign n_orig = (CW'(r_head) < r_nload) &&
                    ((EW'(r_head) + EW'(DEPTH_C) - EW'(r_nload)) >= EW'(r_wcnt));

    // Read the front entry while rotating and for the final take.
    assign rd_en    = (r_state == ST_ROT);
    assign rd_value = r_rd_orig ? r_rd_pos : rd_data;
    assign member_w = {1'b0, rd_value} + 1'b1;

    assign mod_start = s_accept && !i_s_axis_tdata[0] && (r_count != '0) && !n_km1_lt;

    jpg_ring_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_wp_valid),
        .i_wr_addr (r_wp_addr),
        .i_wr_data (rd_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    jpg_mod #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (n_km1),
        .i_divisor  (r_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Read tag: which position was read and whether it still holds its restart value.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_orig <= n_orig;
            r_rd_pos  <= r_head;
        end
    end

    // Tail write address of the rotation in flight.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROT && r_left != '0) begin
            r_wp_addr <= n_tail;
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_nload     <= '0;
            r_wcnt      <= '0;
            r_left      <= '0;
            r_wp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            // Count tail writes since restart, saturating at the depth.
            if (r_wp_valid && r_wcnt != DEPTH_C) begin
                r_wcnt <= r_wcnt + 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (i_s_axis_tdata[0]) begin
                            r_nload      <= n_sat;
                            r_count      <= n_sat;
                            r_head       <= '0;
                            r_wcnt       <= '0;
                            r_out_valid  <= 1'b1;
                            r_out_member <= '0;
                            r_out_last   <= 1'b0;
                            r_out_err    <= 1'b0;
                        end else if (r_count == '0) begin
                            r_out_valid  <= 1'b1;
                            r_out_member <= '0;
                            r_out_last   <= 1'b0;
                            r_out_err    <= 1'b1;
                        end else if (n_km1_lt) begin
                            r_left  <= CW'(n_km1);
                            r_state <= ST_ROT;
                        end else begin
                            r_state <= ST_MOD;
                        end
                    end
                end
                ST_MOD: begin
                    if (mod_done) begin
                        r_left  <= mod_rem;
                        r_state <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (r_left != '0) begin
                        r_wp_valid <= 1'b1;
                        r_head     <= n_head_inc;
                        r_left     <= r_left - 1'b1;
                    end else begin
                        r_wp_valid <= 1'b0;
                        r_state    <= ST_TAKE;
                    end
                end
                ST_TAKE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_member <= jpg_pkg::t_field'(member_w);
                        r_out_err    <= 1'b0;
                        r_count      <= r_count - 1'b1;
                        if (r_count == CW'(1)) begin
                            r_head     <= '0;
                            r_out_last <= 1'b1;
                        end else begin
                            r_head     <= n_head_inc;
                            r_out_last <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result stream.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = jpg_pkg::OUT_TDATA_W'(r_out_member);
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_err;

endmodule

`default_nettype wire

FILE: rtl/core/jpg_checker.sv
`default_nettype none

`include "josephus_permutation_generator_defines.svh"

// Port-level checks on the Josephus generator.
module jpg_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_s_axis_tready,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [jpg_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                            o_m_axis_tlast,
    input wire logic                            o_m_axis_tuser
);

    logic out_stall;

    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    // A stalled result holds its value.
    `JPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
                     o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
                     $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))

    // No new request is taken while a result is blocked.
    `JPG_ASSERT_IMPL(a_no_take_on_stall, i_clk, i_rst_n, out_stall, !o_s_axis_tready)

    // An empty-ring flag carries no member and no last mark.
    `JPG_ASSERT_IMPL(a_err_clean, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser,
                     (o_m_axis_tdata == '0) && !o_m_axis_tlast)

    // The final removal always names a real member.
    `JPG_ASSERT_IMPL(a_last_member, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast,
                     o_m_axis_tdata[jpg_pkg::FIELD_W-1:0] != '0)

endmodule

bind josephus_permutation_generator jpg_checker u_jpg_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int RING_SLOTS = jpg_pkg::DEF_RING_DEPTH;
    localparam int RANDOM_REQUESTS = 1000;

    // One expected result of the generator.
    typedef struct packed {
        jpg_pkg::t_field member;
        logic            last;
        logic            empty_err;
    } t_removal;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                cfg_valid = 1'b0;
    logic [jpg_pkg::CFG_IDX_W-1:0]       cfg_index = jpg_pkg::REG_PEOPLE_COUNT;
    jpg_pkg::t_field                     cfg_data = '0;
    logic                                s_tvalid = 1'b0;
    logic [jpg_pkg::IN_TDATA_W-1:0]      s_tdata = '0;
    logic                                m_tready = 1'b0;

    wire                                 o_cfg_ready;
    wire                                 o_s_axis_tready;
    wire                                 o_m_axis_tvalid;
    wire [jpg_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata;
    wire                                 o_m_axis_tlast;
    wire                                 o_m_axis_tuser;

    // Predictor state: members still standing, front first, and the register copies.
    jpg_pkg::t_field standing[$];
    jpg_pkg::t_field people_cfg = 13'd1;
    jpg_pkg::t_field step_cfg = 13'd1;
    t_removal        expected_removals[$];

    int unsigned fail_count = 0;
    int unsigned requests_sent = 0;
    int unsigned burst_left = 0;
    int unsigned hold_wanted = 0;
    int unsigned hold_left = 0;
    int unsigned pattern_left = 0;
    int unsigned pattern_mode = 0;

    josephus_permutation_generator #(
        .RING_DEPTH(RING_SLOTS)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Generous fixed limit on the whole run.
    initial begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Advance the standing members by one request and return the outcome.
    function automatic t_removal josephus_next(input logic restart);
        t_removal    res;
        int unsigned total;
        int unsigned k;
        int unsigned turns;
        int unsigned i;
        res = '0;
        if (restart) begin
            total = (people_cfg > RING_SLOTS) ? RING_SLOTS : people_cfg;
            standing.delete();
            for (i = 1; i <= total; i++) standing.push_back(jpg_pkg::t_field'(i));
            return res;
        end
        if (standing.size() == 0) begin
            res.empty_err = 1'b1;
            return res;
        end
        k = (step_cfg == 0) ? 1 : step_cfg;
        turns = (k - 1) % standing.size();
        repeat (turns) standing.push_back(standing.pop_front());
        res.member = standing.pop_front();
        res.last = (standing.size() == 0);
        return res;
    endfunction

    // Send one request, in bursts with random gaps between them.
    task automatic send_request(input logic restart);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        @(negedge clk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= jpg_pkg::IN_TDATA_W'(restart);
        do @(posedge clk); while (!o_s_axis_tready);
        expected_removals.push_back(josephus_next(restart));
        burst_left--;
        requests_sent++;
    endtask

    task automatic send_removals(input int unsigned count);
        repeat (count) send_request(1'b0);
    endtask

    // Stop offering requests and wait until every expected result has come.
    task automatic wait_results_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_removals.size() != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [jpg_pkg::CFG_IDX_W-1:0] index,
                                  input int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= jpg_pkg::t_field'(value);
        do @(posedge clk); while (!o_cfg_ready);
        if (index == jpg_pkg::REG_PEOPLE_COUNT) begin
            people_cfg = jpg_pkg::t_field'(value);
        end else begin
            step_cfg = jpg_pkg::t_field'(value);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_circle(input int unsigned people, input int unsigned step);
        wait_results_drained();
        write_register(jpg_pkg::REG_PEOPLE_COUNT, people);
        write_register(jpg_pkg::REG_STEP_COUNT, step);
    endtask

    // Reset values: one member, step one, empty ring.
    task automatic test_reset_values();
        send_removals(1);
        send_request(1'b1);
        send_removals(2);
    endtask

    task automatic test_directed_cases();
        // Classic circle of seven with every third removed, then a request past the end.
        set_circle(7, 3);
        send_request(1'b1);
        send_removals(8);
        // Zero people leaves the ring empty.
        set_circle(0, 2);
        send_request(1'b1);
        send_removals(1);
        // Zero step behaves as step one.
        set_circle(5, 0);
        send_request(1'b1);
        send_removals(2);
        // All ones: people saturate to the ring size, long rotations wrap.
        set_circle(8191, 8191);
        send_request(1'b1);
        send_removals(2);
        // Ring-size values in both registers, restart in the middle of a circle.
        set_circle(4096, 4096);
        send_request(1'b1);
        send_removals(1);
    endtask

    // Hold the result side for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        set_circle(10, 2);
        hold_wanted = 400;
        send_request(1'b1);
        send_removals(15);
    endtask

    task automatic test_random_sequences();
        int unsigned start_count;
        int unsigned people;
        int unsigned step;
        int unsigned loaded;
        int unsigned removals;
        int unsigned kind;
        int unsigned r;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_REQUESTS) begin
            r = $urandom_range(0, 99);
            if (r < 75) people = $urandom_range(1, 40);
            else if (r < 93) people = $urandom_range(41, 300);
            else if (r < 97) people = 0;
            else people = $urandom_range(4090, 8191);
            r = $urandom_range(0, 99);
            if (r < 70) step = $urandom_range(0, 12);
            else if (r < 90) step = $urandom_range(13, 100);
            else if (r < 97) step = $urandom_range(101, 1000);
            else step = $urandom_range(1001, 8191);

            wait_results_drained();
            case ($urandom_range(0, 3))
                0: begin
                    write_register(jpg_pkg::REG_PEOPLE_COUNT, people);
                    write_register(jpg_pkg::REG_STEP_COUNT, step);
                end
                1: begin
                    write_register(jpg_pkg::REG_STEP_COUNT, step);
                    write_register(jpg_pkg::REG_PEOPLE_COUNT, people);
                end
                2: write_register(jpg_pkg::REG_PEOPLE_COUNT, people);
                default: write_register(jpg_pkg::REG_STEP_COUNT, step);
            endcase

            repeat ($urandom_range(1, 3)) begin
                loaded = (people_cfg > RING_SLOTS) ? RING_SLOTS : people_cfg;
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    // Circle run with up to two requests past the end, at most 60 removals (20 past 1000 members).
                    removals = loaded + $urandom_range(0, 2);
                    if (loaded > 1000 && removals > 20) removals = 20;
                    else if (removals > 60) removals = 60;
                    send_request(1'b1);
                    send_removals(removals);
                end else if (kind < 9) begin
                    // Circle cut short by the next restart.
                    removals = $urandom_range(0, (loaded > 40) ? 20 : loaded / 2);
                    send_request(1'b1);
                    send_removals(removals);
                end else begin
                    // Loose requests with occasional restarts.
                    repeat (10) send_request($urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    // Result side: stall patterns of changing density, plus the long hold-off.
    always @(negedge clk) begin
        if (hold_wanted != 0) begin
            hold_left = hold_wanted;
            hold_wanted = 0;
        end
        if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 2);
            pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (pattern_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk) begin
        t_removal want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            if (expected_removals.size() == 0) begin
                report_failure($sformatf("result with no request pending: member %0d",
                                         o_m_axis_tdata[jpg_pkg::FIELD_W-1:0]));
            end else begin
                want = expected_removals.pop_front();
                if (o_m_axis_tdata[jpg_pkg::FIELD_W-1:0] !== want.member)
                    report_failure($sformatf("removed_member got %0d expected %0d",
                                             o_m_axis_tdata[jpg_pkg::FIELD_W-1:0],
                                             want.member));
                if (o_m_axis_tlast !== want.last)
                    report_failure($sformatf("last_removed got %b expected %b",
                                             o_m_axis_tlast, want.last));
                if (o_m_axis_tuser !== want.empty_err)
                    report_failure($sformatf("empty_error got %b expected %b",
                                             o_m_axis_tuser, want.empty_err));
            end
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_directed_cases();
        test_output_backpressure();
        test_random_sequences();

        wait_results_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_removals.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
